// ----- src/tun_pkg.sv -----
package tun_pkg;

    localparam int COORD_BITS       = 16;
    localparam int NORMAL_FRAC_BITS = 14;
    localparam int FIELD_BITS       = 16;
    localparam int OUT_BITS         = 16;

    localparam int EDGE_BITS = COORD_BITS + 1;
    localparam int PROD_BITS = 2 * EDGE_BITS;
    localparam int NRM_BITS  = PROD_BITS + 1;
    localparam int MAG_BITS  = PROD_BITS;
    localparam int K_BITS    = $clog2(MAG_BITS + 1);
    localparam int M_BITS    = 31;
    localparam int SQ_BITS   = 2 * M_BITS;
    localparam int S_BITS    = SQ_BITS + 2;
    localparam int P_BITS    = 2 * (NORMAL_FRAC_BITS + 2) + S_BITS;
    localparam int Q_BITS    = S_BITS + NORMAL_FRAC_BITS + 3;
    localparam int R_BITS    = NORMAL_FRAC_BITS + 1;
    localparam int NUM_CELLS = NORMAL_FRAC_BITS + 1;
    localparam int IDX_BITS  = $clog2(NUM_CELLS);
    localparam int FRONT_STAGES = 6;

    typedef struct packed {
        logic signed [FIELD_BITS-1:0] ax;
        logic signed [FIELD_BITS-1:0] ay;
        logic signed [FIELD_BITS-1:0] az;
        logic signed [FIELD_BITS-1:0] bx;
        logic signed [FIELD_BITS-1:0] by_coord;
        logic signed [FIELD_BITS-1:0] bz;
        logic signed [FIELD_BITS-1:0] cx;
        logic signed [FIELD_BITS-1:0] cy;
        logic signed [FIELD_BITS-1:0] cz;
    } t_in;

    typedef struct packed {
        logic signed [OUT_BITS-1:0] normal_x;
        logic signed [OUT_BITS-1:0] normal_y;
        logic signed [OUT_BITS-1:0] normal_z;
        logic                       degenerate;
    } t_out;

    // one component's search state: p = (2r-1)^2 * s, q = (2r-1) * s
    typedef struct packed {
        logic [P_BITS-1:0]        p;
        logic signed [Q_BITS-1:0] q;
        logic [P_BITS-1:0]        t;
        logic [R_BITS-1:0]        r;
        logic                     neg;
    } t_lane;

    typedef struct packed {
        logic [S_BITS-1:0] s;
        logic              deg;
        t_lane [2:0]       lane;
    } t_srch;

endpackage

// ----- src/tun_front.sv -----
module tun_front
    import tun_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_valid,
    output logic  o_ready,
    input  t_in   i_data,
    output logic  o_valid,
    input  logic  i_ready,
    output t_srch o_data
);

    logic [FRONT_STAGES-1:0] r_v;
    logic [FRONT_STAGES-1:0] en;

    always_comb begin
        en[FRONT_STAGES-1] = !r_v[FRONT_STAGES-1] || i_ready;
        for (int k = FRONT_STAGES - 2; k >= 0; k--) begin
            en[k] = !r_v[k] || en[k+1];
        end
    end

    assign o_ready = en[0];
    assign o_valid = r_v[FRONT_STAGES-1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else begin
            if (en[0]) r_v[0] <= i_valid;
            for (int k = 1; k < FRONT_STAGES; k++) begin
                if (en[k]) r_v[k] <= r_v[k-1];
            end
        end
    end

    // stage 0: edges
    logic signed [COORD_BITS-1:0] ca [2:0];
    logic signed [COORD_BITS-1:0] cb [2:0];
    logic signed [COORD_BITS-1:0] cc [2:0];
    logic signed [EDGE_BITS-1:0]  r_e1 [2:0];
    logic signed [EDGE_BITS-1:0]  r_e2 [2:0];

    always_comb begin
        ca[0] = $signed(i_data.ax[COORD_BITS-1:0]);
        ca[1] = $signed(i_data.ay[COORD_BITS-1:0]);
        ca[2] = $signed(i_data.az[COORD_BITS-1:0]);
        cb[0] = $signed(i_data.bx[COORD_BITS-1:0]);
        cb[1] = $signed(i_data.by_coord[COORD_BITS-1:0]);
        cb[2] = $signed(i_data.bz[COORD_BITS-1:0]);
        cc[0] = $signed(i_data.cx[COORD_BITS-1:0]);
        cc[1] = $signed(i_data.cy[COORD_BITS-1:0]);
        cc[2] = $signed(i_data.cz[COORD_BITS-1:0]);
    end

    always_ff @(posedge i_clk) begin
        if (en[0]) begin
            for (int i = 0; i < 3; i++) begin
                r_e1[i] <= EDGE_BITS'(cb[i]) - EDGE_BITS'(ca[i]);
                r_e2[i] <= EDGE_BITS'(cc[i]) - EDGE_BITS'(ca[i]);
            end
        end
    end

    // stage 1: six cross products
    logic signed [PROD_BITS-1:0] r_pa [2:0];
    logic signed [PROD_BITS-1:0] r_pb [2:0];

    always_ff @(posedge i_clk) begin
        if (en[1]) begin
            r_pa[0] <= PROD_BITS'(r_e1[1]) * PROD_BITS'(r_e2[2]);
            r_pb[0] <= PROD_BITS'(r_e1[2]) * PROD_BITS'(r_e2[1]);
            r_pa[1] <= PROD_BITS'(r_e1[2]) * PROD_BITS'(r_e2[0]);
            r_pb[1] <= PROD_BITS'(r_e1[0]) * PROD_BITS'(r_e2[2]);
            r_pa[2] <= PROD_BITS'(r_e1[0]) * PROD_BITS'(r_e2[1]);
            r_pb[2] <= PROD_BITS'(r_e1[1]) * PROD_BITS'(r_e2[0]);
        end
    end

    // stage 2: normal
    logic signed [NRM_BITS-1:0] r_n [2:0];

    always_ff @(posedge i_clk) begin
        if (en[2]) begin
            for (int i = 0; i < 3; i++) begin
                r_n[i] <= NRM_BITS'(r_pa[i]) - NRM_BITS'(r_pb[i]);
            end
        end
    end

    // stage 3: magnitudes scaled below 2^31
    logic [NRM_BITS-1:0] abs_n [2:0];
    logic [MAG_BITS-1:0] mag [2:0];
    logic [MAG_BITS-1:0] mag_or;
    logic [K_BITS-1:0]   k_sh;
    logic [M_BITS-1:0]   r_m [2:0];
    logic [2:0]          r_neg3;
    logic                r_deg3;

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            abs_n[i] = r_n[i][NRM_BITS-1] ? NRM_BITS'(-r_n[i]) : NRM_BITS'(r_n[i]);
            mag[i]   = abs_n[i][MAG_BITS-1:0];
        end
        mag_or = mag[0] | mag[1] | mag[2];
        k_sh = '0;
        for (int b = M_BITS; b < MAG_BITS; b++) begin
            if (mag_or[b]) k_sh = K_BITS'(b - M_BITS + 1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (en[3]) begin
            for (int i = 0; i < 3; i++) begin
                r_m[i]    <= M_BITS'(mag[i] >> k_sh);
                r_neg3[i] <= r_n[i][NRM_BITS-1];
            end
            r_deg3 <= (mag_or == '0);
        end
    end

    // stage 4: squares
    logic [SQ_BITS-1:0] r_sq [2:0];
    logic [2:0]         r_neg4;
    logic               r_deg4;

    always_ff @(posedge i_clk) begin
        if (en[4]) begin
            for (int i = 0; i < 3; i++) begin
                r_sq[i] <= SQ_BITS'(r_m[i]) * SQ_BITS'(r_m[i]);
            end
            r_neg4 <= r_neg3;
            r_deg4 <= r_deg3;
        end
    end

    // stage 5: sum of squares and per-lane targets, search starts at r = 0
    logic [S_BITS-1:0] s_sum;
    t_srch             r_out;

    assign s_sum = S_BITS'(r_sq[0]) + S_BITS'(r_sq[1]) + S_BITS'(r_sq[2]);

    always_ff @(posedge i_clk) begin
        if (en[5]) begin
            r_out.s   <= s_sum;
            r_out.deg <= r_deg4;
            for (int i = 0; i < 3; i++) begin
                r_out.lane[i].p   <= P_BITS'(s_sum);
                r_out.lane[i].q   <= -$signed(Q_BITS'(s_sum));
                r_out.lane[i].t   <= P_BITS'(r_sq[i]) << (2 * NORMAL_FRAC_BITS + 2);
                r_out.lane[i].r   <= '0;
                r_out.lane[i].neg <= r_neg4[i];
            end
        end
    end

    assign o_data = r_out;

endmodule

// ----- src/tun_cell.sv -----
module tun_cell
    import tun_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic [IDX_BITS-1:0] i_bit_idx,
    input  logic                i_valid,
    output logic                o_ready,
    input  t_srch               i_data,
    output logic                o_valid,
    input  logic                i_ready,
    output t_srch               o_data
);

    localparam int W = P_BITS + 2;

    logic  r_valid;
    t_srch r_data;
    t_srch n_data;
    logic  en;

    logic signed [W-1:0]      qx [2:0];
    logic signed [W-1:0]      sx;
    logic signed [W-1:0]      pc [2:0];
    logic [Q_BITS-1:0]        qs;
    logic signed [Q_BITS-1:0] qn [2:0];
    logic [2:0]               fit;

    assign en      = !r_valid || i_ready;
    assign o_ready = en;
    assign o_valid = r_valid;
    assign o_data  = r_data;

    // try r + 2^j using incremental square updates
    always_comb begin
        n_data = i_data;
        sx = $signed(W'(i_data.s));
        qs = Q_BITS'(Q_BITS'(i_data.s) << (32'(i_bit_idx) + 1));
        for (int i = 0; i < 3; i++) begin
            qx[i] = W'(i_data.lane[i].q);
            pc[i] = $signed(W'(i_data.lane[i].p))
                  + (qx[i] <<< (32'(i_bit_idx) + 2))
                  + (sx <<< (2 * 32'(i_bit_idx) + 2));
            qn[i] = i_data.lane[i].q + $signed(qs);
            fit[i] = (pc[i][W-1:P_BITS] == '0) &&
                     (pc[i][P_BITS-1:0] <= i_data.lane[i].t);
            if (fit[i]) begin
                n_data.lane[i].p = pc[i][P_BITS-1:0];
                n_data.lane[i].q = qn[i];
                n_data.lane[i].r = i_data.lane[i].r | (R_BITS'(1) << i_bit_idx);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (en) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_data <= n_data;
        end
    end

endmodule

// ----- src/triangle_unit_normal_core.sv -----
// Unit face normal of one triangle. Each transfer on the input channel carries three
// vertices with signed 16-bit coordinates; each transfer on the output channel carries
// the normal (b-a) x (c-a) divided by its length, in signed Q1.14, components rounded
// half away from zero and lying in -16384..16384. A triangle whose cross product is
// zero gives an all-zero normal with degenerate set. Without backpressure, one
// triangle is taken per clock cycle and one result leaves per cycle. 6 front stages
// (edges, products, cross, scale, squares, sum) feed one search cell per result bit
// (15), then the output register. The rounded square-root division is a chain of 15
// identical cells, each settling one result bit for all three components by shift and
// add updates of (2r-1)^2*s. Every stage holds its item under backpressure and empty
// stages fill in, so input stays ready as long as the pipeline has a free slot.
module triangle_unit_normal_core
    import tun_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_in_valid,
    output logic o_in_ready,
    input  t_in  i_in_data,
    output logic o_out_valid,
    input  logic i_out_ready,
    output t_out o_out_data
);

    // front pipeline: cross product, scaling, sum of squares
    logic  f_valid;
    logic  f_ready;
    t_srch f_data;

    tun_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_in_valid),
        .o_ready (o_in_ready),
        .i_data  (i_in_data),
        .o_valid (f_valid),
        .i_ready (f_ready),
        .o_data  (f_data)
    );

    // search chain, cell c settles result bit NORMAL_FRAC_BITS - c
    logic  c_valid [NUM_CELLS:0];
    logic  c_ready [NUM_CELLS:0];
    t_srch c_data  [NUM_CELLS:0];

    assign c_valid[0] = f_valid;
    assign c_data[0]  = f_data;
    assign f_ready    = c_ready[0];

    for (genvar c = 0; c < NUM_CELLS; c++) begin : g_cell
        tun_cell u_cell (
            .i_clk     (i_clk),
            .i_rst_n   (i_rst_n),
            .i_bit_idx (IDX_BITS'(NORMAL_FRAC_BITS - c)),
            .i_valid   (c_valid[c]),
            .o_ready   (c_ready[c]),
            .i_data    (c_data[c]),
            .o_valid   (c_valid[c+1]),
            .i_ready   (c_ready[c+1]),
            .o_data    (c_data[c+1])
        );
    end

    // output register: apply sign, force zero on degenerate triangles
    localparam int V_BITS = R_BITS + 1 + OUT_BITS;

    logic             r_out_valid;
    t_out             r_out_data;
    t_out             n_out_data;
    logic             out_en;
    logic [V_BITS-1:0] mag_v [2:0];
    logic [V_BITS-1:0] sgn_v [2:0];

    assign out_en = !r_out_valid || i_out_ready;
    assign c_ready[NUM_CELLS] = out_en;

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            mag_v[i] = V_BITS'(c_data[NUM_CELLS].lane[i].r);
            sgn_v[i] = c_data[NUM_CELLS].lane[i].neg ? (~mag_v[i] + V_BITS'(1)) : mag_v[i];
            if (c_data[NUM_CELLS].deg) sgn_v[i] = '0;
        end
        n_out_data.normal_x   = $signed(sgn_v[0][OUT_BITS-1:0]);
        n_out_data.normal_y   = $signed(sgn_v[1][OUT_BITS-1:0]);
        n_out_data.normal_z   = $signed(sgn_v[2][OUT_BITS-1:0]);
        n_out_data.degenerate = c_data[NUM_CELLS].deg;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_en) begin
            r_out_valid <= c_valid[NUM_CELLS];
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_en) begin
            r_out_data <= n_out_data;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

endmodule

// ----- src/tun_checker.sv -----
module tun_checker
    import tun_pkg::*;
(
    input logic i_clk,
    input logic i_rst_n,
    input logic i_in_valid,
    input logic o_in_ready,
    input t_in  i_in_data,
    input logic o_out_valid,
    input logic i_out_ready,
    input t_out o_out_data
);

    // waiting input transfer holds
    a_in_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_ready |=> i_in_valid && $stable(i_in_data))
        else $error("input changed while waiting");

    // stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_out_data))
        else $error("output changed while stalled");

    // degenerate triangles report a zero normal
    a_deg_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_data.degenerate |->
            o_out_data.normal_x == '0 && o_out_data.normal_y == '0 &&
            o_out_data.normal_z == '0)
        else $error("degenerate result with nonzero normal");

    // an empty output register frees the whole pipeline
    a_ready_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_out_valid |-> o_in_ready)
        else $error("input stalled with empty output");

    // reset empties the output
    a_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("output valid after reset");

endmodule

bind triangle_unit_normal_core tun_checker u_tun_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_ready  (o_in_ready),
    .i_in_data   (i_in_data),
    .o_out_valid (o_out_valid),
    .i_out_ready (i_out_ready),
    .o_out_data  (o_out_data)
);
